// ===== hw/rtl/itrb_pkg.sv =====
package itrb_pkg;

  // bank and terminal window geometry
  localparam int BANK_BYTES     = 128;
  localparam int TERMINAL_BYTES = 32;
  localparam int TERMINAL_BASE  = 256;

  localparam int BANK_AW = $clog2(BANK_BYTES);
  localparam int TERM_AW = $clog2(TERMINAL_BYTES);

  // the clearing pass covers the larger of the two stores
  localparam int CLR_N  = (BANK_BYTES > TERMINAL_BYTES) ? BANK_BYTES : TERMINAL_BYTES;
  localparam int CLR_AW = $clog2(CLR_N);

  // pointer value that routes bus writes to the terminal buffer
  localparam logic [7:0] PTR_TERMINAL   = 8'hff;
  // byte returned by a bus read past the bank
  localparam logic [7:0] BYTE_PAST_BANK = 8'hff;

  // action codes
  localparam logic [2:0] ACT_ADDR_WRITE = 3'd0;
  localparam logic [2:0] ACT_ADDR_READ  = 3'd1;
  localparam logic [2:0] ACT_BYTE_IN    = 3'd2;
  localparam logic [2:0] ACT_BYTE_SENT  = 3'd3;
  localparam logic [2:0] ACT_LOC_READ   = 3'd4;
  localparam logic [2:0] ACT_LOC_WRITE  = 3'd5;
  localparam logic [2:0] ACT_FLAG_QUERY = 3'd6;
  localparam logic [2:0] ACT_NOP        = 3'd7;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  bus_byte;
    logic [15:0] local_address;
    logic [2:0]  access_width;
    logic [31:0] write_data;
  } in_t;

  typedef struct packed {
    logic        reply_valid;
    logic [31:0] reply_data;
    logic        changed;
    logic        write_notice;
    logic [7:0]  notice_address;
  } out_t;

  // one bank entry: changed flag next to its data byte
  typedef struct packed {
    logic       flag;
    logic [7:0] data;
  } bank_word_t;

endpackage

// ===== hw/rtl/itrb_ram.sv =====
module itrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/i2c_target_register_bank.sv =====
// sequence: an accepted item enters a first state; address phases, bus bytes in, pushes and
// empty accesses strobe from there; the rest take a read and a write step for each byte, in
// the bank or past it (bus fetch, one-byte reads, up to four bytes local, up to seven flags)
// busy stays high through the read-then-write loop on the bank ram; a new transaction waits for idle
// reset: rst_n low clears control state; then a clearing pass over every bank entry zeroes bank,
// flags and terminal buffer while busy is high; the receiver cannot stall the result strobe
module i2c_target_register_bank (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  itrb_pkg::in_t     in_item,
  output logic              busy,
  output logic              out_strobe,
  output itrb_pkg::out_t    out_item
);

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FIRST = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_WR    = 3'd4;

  // bus transaction phase
  localparam logic [1:0] PH_WAITING  = 2'd0;
  localparam logic [1:0] PH_GET_ADDR = 2'd1;
  localparam logic [1:0] PH_GET_DATA = 2'd2;
  localparam logic [1:0] PH_SEND     = 2'd3;

  localparam logic [16:0] BANK_END  = 17'(itrb_pkg::BANK_BYTES);
  localparam logic [16:0] TERM_LO   = 17'(itrb_pkg::TERMINAL_BASE);
  localparam logic [16:0] TERM_HI   = 17'(itrb_pkg::TERMINAL_BASE + itrb_pkg::TERMINAL_BYTES);
  localparam logic [itrb_pkg::TERM_AW:0] TERM_CNT =
    (itrb_pkg::TERM_AW + 1)'(itrb_pkg::TERMINAL_BYTES);
  localparam logic [itrb_pkg::TERM_AW-1:0] TERM_LAST =
    itrb_pkg::TERM_AW'(itrb_pkg::TERMINAL_BYTES - 1);
  localparam logic [itrb_pkg::CLR_AW:0] CLR_BANK_END =
    (itrb_pkg::CLR_AW + 1)'(itrb_pkg::BANK_BYTES);
  localparam logic [itrb_pkg::CLR_AW:0] CLR_TERM_END =
    (itrb_pkg::CLR_AW + 1)'(itrb_pkg::TERMINAL_BYTES);
  localparam logic [itrb_pkg::CLR_AW-1:0] CLR_LAST =
    itrb_pkg::CLR_AW'(itrb_pkg::CLR_N - 1);

  // control and accumulated result
  logic [2:0]                   state_r, state_nxt;
  itrb_pkg::in_t                item_r, item_nxt;
  itrb_pkg::out_t               res_r, res_nxt;
  logic                         strobe_r, strobe_nxt;
  logic [1:0]                   phase_r, phase_nxt;
  logic [7:0]                   pointer_r, pointer_nxt;
  logic                         tchg_r, tchg_nxt;
  logic [itrb_pkg::TERM_AW-1:0] head_r, head_nxt;
  logic [itrb_pkg::CLR_AW-1:0]  clr_r, clr_nxt;
  logic [2:0]                   cnt_r, cnt_nxt;
  logic [2:0]                   n_r, n_nxt;

  // decode of the held transaction
  logic [2:0]                   act;
  logic [2:0]                   wid;
  logic [16:0]                  addr_ext;
  logic [16:0]                  byte_a;
  logic                         fetch;
  logic                         loc_rw;
  logic                         width_one;
  logic                         addr_bank;
  logic                         addr_term;
  logic                         term_rd;
  logic                         byte_in_bank;
  logic [2:0]                   n_first;
  logic                         last;
  logic [4:0]                   lane;
  logic [7:0]                   wbyte;
  logic [15:0]                  term_off;
  logic [itrb_pkg::TERM_AW:0]   term_sum;
  logic [itrb_pkg::TERM_AW-1:0] term_raddr;
  logic [itrb_pkg::TERM_AW-1:0] head_inc;
  logic                         push_en;
  logic [7:0]                   push_byte;

  // ram ports
  logic                         bank_we;
  logic [itrb_pkg::BANK_AW-1:0] bank_waddr;
  itrb_pkg::bank_word_t         bank_wdata;
  logic [itrb_pkg::BANK_AW-1:0] bank_raddr;
  itrb_pkg::bank_word_t         bank_rdata;
  logic                         term_we;
  logic [itrb_pkg::TERM_AW-1:0] term_waddr;
  logic [7:0]                   term_wdata;
  logic [7:0]                   term_rdata;

  // bank ram: data byte and changed flag per entry, read-modify-write
  itrb_ram #(
    .WIDTH($bits(itrb_pkg::bank_word_t)),
    .DEPTH(itrb_pkg::BANK_BYTES)
  ) u_bank_ram (
    .clk   (clk),
    .we    (bank_we),
    .waddr (bank_waddr),
    .wdata (bank_wdata),
    .raddr (bank_raddr),
    .rdata (bank_rdata)
  );

  // terminal buffer: circular store, head_r marks the oldest byte
  itrb_ram #(
    .WIDTH(8),
    .DEPTH(itrb_pkg::TERMINAL_BYTES)
  ) u_term_ram (
    .clk   (clk),
    .we    (term_we),
    .waddr (term_waddr),
    .wdata (term_wdata),
    .raddr (term_raddr),
    .rdata (term_rdata)
  );

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_item   = res_r;

  // field decode
  assign act       = item_r.action;
  assign wid       = item_r.access_width;
  assign addr_ext  = {1'b0, item_r.local_address};
  assign width_one = (wid == 3'd1);
  assign addr_bank = (addr_ext < BANK_END);
  assign addr_term = (addr_ext >= TERM_LO) && (addr_ext < TERM_HI);
  assign loc_rw    = (act == itrb_pkg::ACT_LOC_READ) || (act == itrb_pkg::ACT_LOC_WRITE);
  assign term_rd   = (act == itrb_pkg::ACT_LOC_READ) && width_one && !addr_bank && addr_term;

  // bus fetch: address read, or byte sent while in the send phase
  assign fetch = (act == itrb_pkg::ACT_ADDR_READ) ||
                 ((act == itrb_pkg::ACT_BYTE_SENT) && (phase_r == PH_SEND));

  // byte address of the current loop step; same in the read and write cycles
  assign byte_a       = fetch ? {9'b0, pointer_r} : (addr_ext + 17'(cnt_r));
  assign byte_in_bank = (byte_a < BANK_END);
  assign bank_raddr   = byte_in_bank ? byte_a[itrb_pkg::BANK_AW-1:0] : '0;

  // terminal logical index to physical slot, one conditional subtract
  assign term_off   = item_r.local_address - 16'(itrb_pkg::TERMINAL_BASE);
  assign term_sum   = {1'b0, head_r} + {1'b0, term_off[itrb_pkg::TERM_AW-1:0]};
  assign term_raddr = (term_sum >= TERM_CNT) ? itrb_pkg::TERM_AW'(term_sum - TERM_CNT)
                                             : term_sum[itrb_pkg::TERM_AW-1:0];
  assign head_inc   = (head_r == TERM_LAST) ? '0 : head_r + 1'b1;

  assign lane  = {cnt_r[1:0], 3'b000};
  assign wbyte = item_r.write_data[lane +: 8];
  assign last  = ((cnt_r + 3'd1) == n_r);

  // number of bank (or terminal read) steps the transaction needs
  always_comb begin
    n_first = 3'd0;
    if (fetch) begin
      n_first = 3'd1;
    end else if (loc_rw) begin
      if (width_one) begin
        n_first = (addr_bank || term_rd) ? 3'd1 : 3'd0;
      end else if (wid > 3'd4) begin
        n_first = 3'd4;
      end else begin
        n_first = wid;
      end
    end else if ((act == itrb_pkg::ACT_FLAG_QUERY) && addr_bank) begin
      n_first = wid;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    res_nxt     = res_r;
    strobe_nxt  = 1'b0;
    phase_nxt   = phase_r;
    pointer_nxt = pointer_r;
    tchg_nxt    = tchg_r;
    head_nxt    = head_r;
    clr_nxt     = clr_r;
    cnt_nxt     = cnt_r;
    n_nxt       = n_r;
    bank_we     = 1'b0;
    bank_waddr  = '0;
    bank_wdata  = '0;
    term_we     = 1'b0;
    term_waddr  = '0;
    term_wdata  = '0;
    push_en     = 1'b0;
    push_byte   = '0;

    unique case (state_r)
      // zero both stores, one entry per cycle in each store still within its depth
      S_CLEAR: begin
        bank_we    = ({1'b0, clr_r} < CLR_BANK_END);
        bank_waddr = clr_r[itrb_pkg::BANK_AW-1:0];
        term_we    = ({1'b0, clr_r} < CLR_TERM_END);
        term_waddr = clr_r[itrb_pkg::TERM_AW-1:0];
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (start) begin
          item_nxt  = in_item;
          res_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_FIRST;
        end
      end

      // immediate effects; first ram read goes out in this cycle
      S_FIRST: begin
        case (act)
          itrb_pkg::ACT_ADDR_WRITE: begin
            phase_nxt = PH_GET_ADDR;
          end
          itrb_pkg::ACT_ADDR_READ: begin
            phase_nxt           = PH_SEND;
            res_nxt.reply_valid = 1'b1;
          end
          itrb_pkg::ACT_BYTE_IN: begin
            if (phase_r == PH_GET_ADDR) begin
              pointer_nxt = item_r.bus_byte;
              phase_nxt   = PH_GET_DATA;
            end else if (phase_r == PH_GET_DATA) begin
              if (pointer_r == itrb_pkg::PTR_TERMINAL) begin
                push_en   = 1'b1;
                push_byte = item_r.bus_byte;
              end else if (pointer_r < 8'(itrb_pkg::BANK_BYTES)) begin
                // store without a read: flag and byte are both overwritten
                bank_we                = 1'b1;
                bank_waddr             = pointer_r[itrb_pkg::BANK_AW-1:0];
                bank_wdata.flag        = 1'b1;
                bank_wdata.data        = item_r.bus_byte;
                res_nxt.write_notice   = 1'b1;
                res_nxt.notice_address = pointer_r;
                pointer_nxt            = pointer_r + 8'd1;
              end
            end
          end
          itrb_pkg::ACT_BYTE_SENT: begin
            res_nxt.reply_valid = (phase_r == PH_SEND);
          end
          itrb_pkg::ACT_LOC_READ: begin
            res_nxt.reply_valid = 1'b1;
          end
          itrb_pkg::ACT_LOC_WRITE: begin
            if (width_one && !addr_bank && addr_term) begin
              push_en   = 1'b1;
              push_byte = item_r.write_data[7:0];
            end
          end
          itrb_pkg::ACT_FLAG_QUERY: begin
            if (!addr_bank && addr_term) begin
              res_nxt.changed = tchg_r;
              tchg_nxt        = 1'b0;
            end
          end
          default: begin
          end
        endcase
        if (n_first == 3'd0) begin
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          n_nxt     = n_first;
          state_nxt = S_WR;
        end
      end

      // read issued for the current step
      S_RD: begin
        state_nxt = S_WR;
      end

      // read data back: merge it into the reply, or modify and write the entry
      S_WR: begin
        if (term_rd) begin
          res_nxt.reply_data = {24'b0, term_rdata};
        end else if (fetch) begin
          res_nxt.reply_data = {24'b0, byte_in_bank ? bank_rdata.data
                                                    : itrb_pkg::BYTE_PAST_BANK};
          pointer_nxt = pointer_r + 8'd1;
        end else if (byte_in_bank) begin
          case (act)
            itrb_pkg::ACT_LOC_READ: begin
              res_nxt.reply_data[lane +: 8] = bank_rdata.data;
            end
            itrb_pkg::ACT_LOC_WRITE: begin
              bank_we         = 1'b1;
              bank_waddr      = byte_a[itrb_pkg::BANK_AW-1:0];
              bank_wdata.flag = 1'b1;
              bank_wdata.data = wbyte;
            end
            itrb_pkg::ACT_FLAG_QUERY: begin
              res_nxt.changed = res_r.changed | bank_rdata.flag;
              bank_we         = 1'b1;
              bank_waddr      = byte_a[itrb_pkg::BANK_AW-1:0];
              bank_wdata.flag = 1'b0;
              bank_wdata.data = bank_rdata.data;
            end
            default: begin
            end
          endcase
        end
        if (last) begin
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cnt_nxt   = cnt_r + 3'd1;
          state_nxt = S_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // shift into the terminal buffer: newest byte over the oldest slot
    if (push_en) begin
      term_we    = 1'b1;
      term_waddr = head_r;
      term_wdata = push_byte;
      head_nxt   = head_inc;
      tchg_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      strobe_r  <= 1'b0;
      phase_r   <= PH_WAITING;
      pointer_r <= '0;
      tchg_r    <= 1'b0;
      head_r    <= '0;
      clr_r     <= '0;
      cnt_r     <= '0;
      n_r       <= '0;
      res_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      strobe_r  <= strobe_nxt;
      phase_r   <= phase_nxt;
      pointer_r <= pointer_nxt;
      tchg_r    <= tchg_nxt;
      head_r    <= head_nxt;
      clr_r     <= clr_nxt;
      cnt_r     <= cnt_nxt;
      n_r       <= n_nxt;
      res_r     <= res_nxt;
    end
  end

  // held transaction needs no reset
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  // result strobe only once the sequencer has returned to idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while sequencer busy");

  // a write notice always names a bank entry
  a_notice_in_bank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.write_notice) |->
      (out_item.notice_address < 8'(itrb_pkg::BANK_BYTES)))
    else $error("write notice outside the bank");

  // loop step stays inside its byte count
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_WR) || (state_r == S_RD)) |-> (cnt_r < n_r))
    else $error("loop step past byte count");

  // terminal head never leaves the buffer
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, head_r} < TERM_CNT))
    else $error("terminal head out of range");

  // an accepted transaction starts work and never strobes in its first cycle
  a_accept_first: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ((state_r == S_FIRST) && !out_strobe))
    else $error("accepted transaction did not start");

endmodule

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import itrb_pkg::*;

  // run length and watchdog
  localparam int RANDOM_ITEMS = 600;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int PRINT_LIMIT  = 200;

  // sender idle chances, one entry per block of a hundred random transactions
  localparam int IDLE_PLAN [6] = '{0, 51, 18, 0, 51, 18};

  // bus-side phase of the target
  typedef enum logic [1:0] {PH_WAITING, PH_GET_PTR, PH_GET_DATA, PH_SENDING} bus_phase_t;

  // directed row: transaction, whether its result is written in, and that result
  typedef struct packed {
    in_t  stim;
    logic typed;
    out_t golden;
  } directed_row_t;

  typedef struct {
    in_t  item;
    logic typed;
    out_t golden;
    int   idle_pct;
  } stim_t;

  localparam logic TYPED     = 1'b1;
  localparam logic PREDICTED = 1'b0;
  localparam out_t NO_GOLDEN = '0;

  // directed part: extremes, every action and the awkward corners of the bus side
  localparam int DIRECTED_ROWS = 26;
  directed_row_t directed_table [DIRECTED_ROWS] = '{
    // fresh out of reset everything reads zero
    {ACT_LOC_READ,   8'h00, 16'h0000, 3'd4, 32'h0, TYPED, 1'b1, 32'h0, 1'b0, 1'b0, 8'h00},
    {ACT_FLAG_QUERY, 8'h00, 16'h0000, 3'd7, 32'h0, TYPED, 1'b0, 32'h0, 1'b0, 1'b0, 8'h00},
    // bus bytes outside a transfer are ignored
    {ACT_BYTE_SENT,  8'h00, 16'h0000, 3'd0, 32'h0, TYPED, 1'b0, 32'h0, 1'b0, 1'b0, 8'h00},
    {ACT_BYTE_IN,    8'hff, 16'h0000, 3'd0, 32'h0, TYPED, 1'b0, 32'h0, 1'b0, 1'b0, 8'h00},
    {ACT_NOP, 8'hff, 16'hffff, 3'd7, 32'hffffffff, TYPED, 1'b0, 32'h0, 1'b0, 1'b0, 8'h00},
    // bus write across the end of the bank
    {ACT_ADDR_WRITE, 8'h00, 16'h0000, 3'd0, 32'h0, TYPED, 1'b0, 32'h0, 1'b0, 1'b0, 8'h00},
    {ACT_BYTE_IN,    8'h7e, 16'h0000, 3'd0, 32'h0, TYPED, 1'b0, 32'h0, 1'b0, 1'b0, 8'h00},
    {ACT_BYTE_IN,    8'hff, 16'h0000, 3'd0, 32'h0, TYPED, 1'b0, 32'h0, 1'b0, 1'b1, 8'h7e},
    {ACT_BYTE_IN,    8'h00, 16'h0000, 3'd0, 32'h0, TYPED, 1'b0, 32'h0, 1'b0, 1'b1, 8'h7f},
    {ACT_BYTE_IN,    8'h55, 16'h0000, 3'd0, 32'h0, TYPED, 1'b0, 32'h0, 1'b0, 1'b0, 8'h00},
    // read past the bank gives 0xff; a byte in while sending is dropped
    {ACT_ADDR_READ,  8'h00, 16'h0000, 3'd0, 32'h0, TYPED, 1'b1, 32'hff, 1'b0, 1'b0, 8'h00},
    {ACT_BYTE_IN,    8'h33, 16'h0000, 3'd0, 32'h0, TYPED, 1'b0, 32'h0, 1'b0, 1'b0, 8'h00},
    // pointer 0xff routes the data byte into the terminal buffer
    {ACT_ADDR_WRITE, 8'h00, 16'h0000, 3'd0, 32'h0, TYPED, 1'b0, 32'h0, 1'b0, 1'b0, 8'h00},
    {ACT_BYTE_IN,    8'hff, 16'h0000, 3'd0, 32'h0, TYPED, 1'b0, 32'h0, 1'b0, 1'b0, 8'h00},
    {ACT_BYTE_IN,    8'ha5, 16'h0000, 3'd0, 32'h0, TYPED, 1'b0, 32'h0, 1'b0, 1'b0, 8'h00},
    {ACT_FLAG_QUERY, 8'h00, 16'h0100, 3'd0, 32'h0, TYPED, 1'b0, 32'h0, 1'b1, 1'b0, 8'h00},
    {ACT_LOC_READ,   8'h00, 16'h011f, 3'd1, 32'h0, TYPED, 1'b1, 32'ha5, 1'b0, 1'b0, 8'h00},
    // local accesses that run off the end of the bank, then a terminal write
    {ACT_LOC_READ,   8'h00, 16'h007e, 3'd2, 32'h0, TYPED, 1'b1, 32'hff, 1'b0, 1'b0, 8'h00},
    {ACT_FLAG_QUERY, 8'h00, 16'h007e, 3'd7, 32'h0, TYPED, 1'b0, 32'h0, 1'b1, 1'b0, 8'h00},
    {ACT_LOC_WRITE,  8'h00, 16'h007d, 3'd4, 32'hdeadbeef, PREDICTED, NO_GOLDEN},
    {ACT_LOC_READ,   8'h00, 16'h007c, 3'd7, 32'h0, PREDICTED, NO_GOLDEN},
    {ACT_LOC_WRITE,  8'h00, 16'h0110, 3'd1, 32'h12345678, PREDICTED, NO_GOLDEN},
    // width one outside both windows, and width zero
    {ACT_LOC_READ,   8'h00, 16'hffff, 3'd1, 32'h0, TYPED, 1'b1, 32'h0, 1'b0, 1'b0, 8'h00},
    {ACT_LOC_READ,   8'h00, 16'h0000, 3'd0, 32'h0, TYPED, 1'b1, 32'h0, 1'b0, 1'b0, 8'h00},
    // pointer still at 0xff: read gives 0xff and the pointer wraps to zero
    {ACT_ADDR_READ,  8'h00, 16'h0000, 3'd0, 32'h0, TYPED, 1'b1, 32'hff, 1'b0, 1'b0, 8'h00},
    {ACT_BYTE_SENT,  8'h00, 16'h0000, 3'd0, 32'h0, PREDICTED, NO_GOLDEN}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t  in_item = '0;
  logic busy;
  logic out_strobe;
  out_t out_item;

  i2c_target_register_bank dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_item    (in_item),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  always #4 clk = ~clk;

  // shadow copy of the target's stores
  logic [7:0] bank_copy [BANK_BYTES];
  logic       flag_copy [BANK_BYTES];
  logic [7:0] term_copy [TERMINAL_BYTES];
  logic       term_flag;
  logic [7:0] bus_pointer;
  bus_phase_t bus_phase;

  stim_t stim_queue [$];
  out_t  expected_replies [$];
  stim_t presented;
  out_t  predicted_now;
  int    random_count;
  int    mismatch_count;
  int    cycle_count;

  function automatic logic in_window(input int addr);
    return addr >= TERMINAL_BASE && addr < TERMINAL_BASE + TERMINAL_BYTES;
  endfunction

  // terminal buffer shifts towards index zero, newest byte at the top
  function automatic void push_terminal(input logic [7:0] b);
    int i;
    for (i = 0; i < TERMINAL_BYTES - 1; i++) begin
      term_copy[i] = term_copy[i + 1];
    end
    term_copy[TERMINAL_BYTES - 1] = b;
    term_flag = 1'b1;
  endfunction

  function automatic logic [7:0] fetch_bus_byte();
    logic [7:0] b;
    b = (bus_pointer < BANK_BYTES) ? bank_copy[bus_pointer] : BYTE_PAST_BANK;
    bus_pointer = bus_pointer + 8'd1;
    return b;
  endfunction

  // applies one transaction to the shadow stores and returns its reply
  function automatic out_t predict_reply(input in_t t);
    out_t r;
    int   n;
    int   i;
    int   a;
    r = '0;
    case (t.action)
      ACT_ADDR_WRITE: begin
        bus_phase = PH_GET_PTR;
      end
      ACT_ADDR_READ: begin
        bus_phase = PH_SENDING;
        r.reply_valid = 1'b1;
        r.reply_data = {24'h0, fetch_bus_byte()};
      end
      ACT_BYTE_IN: begin
        if (bus_phase == PH_GET_PTR) begin
          bus_pointer = t.bus_byte;
          bus_phase = PH_GET_DATA;
        end else if (bus_phase == PH_GET_DATA) begin
          if (bus_pointer == PTR_TERMINAL) begin
            push_terminal(t.bus_byte);
          end else if (bus_pointer < BANK_BYTES) begin
            bank_copy[bus_pointer] = t.bus_byte;
            flag_copy[bus_pointer] = 1'b1;
            r.write_notice = 1'b1;
            r.notice_address = bus_pointer;
            bus_pointer = bus_pointer + 8'd1;
          end
        end
      end
      ACT_BYTE_SENT: begin
        if (bus_phase == PH_SENDING) begin
          r.reply_valid = 1'b1;
          r.reply_data = {24'h0, fetch_bus_byte()};
        end
      end
      ACT_LOC_READ: begin
        r.reply_valid = 1'b1;
        if (t.access_width == 3'd1) begin
          if (t.local_address < BANK_BYTES) begin
            r.reply_data = {24'h0, bank_copy[t.local_address]};
          end else if (in_window(t.local_address)) begin
            r.reply_data = {24'h0, term_copy[t.local_address - TERMINAL_BASE]};
          end
        end else begin
          n = (t.access_width > 3'd4) ? 4 : t.access_width;
          for (i = 0; i < n; i++) begin
            a = t.local_address + i;
            if (a < BANK_BYTES) begin
              r.reply_data = r.reply_data | (32'(bank_copy[a]) << (8 * i));
            end
          end
        end
      end
      ACT_LOC_WRITE: begin
        if (t.access_width == 3'd1) begin
          if (t.local_address < BANK_BYTES) begin
            bank_copy[t.local_address] = t.write_data[7:0];
            flag_copy[t.local_address] = 1'b1;
          end else if (in_window(t.local_address)) begin
            push_terminal(t.write_data[7:0]);
          end
        end else begin
          n = (t.access_width > 3'd4) ? 4 : t.access_width;
          for (i = 0; i < n; i++) begin
            a = t.local_address + i;
            if (a < BANK_BYTES) begin
              bank_copy[a] = t.write_data[8 * i +: 8];
              flag_copy[a] = 1'b1;
            end
          end
        end
      end
      ACT_FLAG_QUERY: begin
        if (t.local_address < BANK_BYTES) begin
          for (i = 0; i < t.access_width; i++) begin
            a = t.local_address + i;
            if (a < BANK_BYTES) begin
              r.changed = r.changed | flag_copy[a];
              flag_copy[a] = 1'b0;
            end
          end
        end else if (in_window(t.local_address)) begin
          r.changed = term_flag;
          term_flag = 1'b0;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // every field random, so all input bits toggle even where they are ignored
  function automatic in_t random_item();
    in_t t;
    t.action        = 3'($urandom_range(7, 0));
    t.bus_byte      = 8'($urandom());
    t.local_address = 16'($urandom());
    t.access_width  = 3'($urandom_range(7, 0));
    t.write_data    = $urandom();
    return t;
  endfunction

  // register pointer, biased to the bank end, the terminal code and wrap
  function automatic logic [7:0] pick_pointer();
    case ($urandom_range(9, 0))
      0, 1:    return PTR_TERMINAL;
      2:       return 8'($urandom_range(BANK_BYTES + 8, BANK_BYTES - 8));
      3:       return 8'($urandom_range(255, 0));
      default: return 8'($urandom_range(BANK_BYTES - 1, 0));
    endcase
  endfunction

  function automatic logic [15:0] pick_local_address();
    case ($urandom_range(9, 0))
      0, 1: return 16'(TERMINAL_BASE + $urandom_range(TERMINAL_BYTES - 1, 0));
      2: begin
        case ($urandom_range(2, 0))
          0:       return 16'(BANK_BYTES - 4 + $urandom_range(7, 0));
          1:       return 16'(TERMINAL_BASE - 2 + $urandom_range(3, 0));
          default: return 16'(TERMINAL_BASE + TERMINAL_BYTES - 2 + $urandom_range(3, 0));
        endcase
      end
      3:       return 16'($urandom());
      default: return 16'($urandom_range(BANK_BYTES - 1, 0));
    endcase
  endfunction

  task automatic queue_item(input in_t t);
    stim_t s;
    s.item     = t;
    s.typed    = PREDICTED;
    s.golden   = NO_GOLDEN;
    s.idle_pct = IDLE_PLAN[(random_count / 100) % 6];
    stim_queue.push_back(s);
    random_count++;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic check_field(input string field, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch(field, got, want);
    end
  endtask

  // sender: a transaction is taken at an edge where start is high and busy low;
  // start then stays high with the next item or drops while the sender idles
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        // predictor always runs so the shadow stores track typed rows as well
        predicted_now = predict_reply(in_item);
        expected_replies.push_back(presented.typed ? presented.golden : predicted_now);
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (stim_queue.size() != 0 &&
                   $urandom_range(99, 0) >= stim_queue[0].idle_pct) begin
        presented = stim_queue.pop_front();
        in_item <= presented.item;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // receiver: every strobe is a reply and must match the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("reply with nothing outstanding", out_item.reply_data, 32'h0);
      end else begin
        check_field("reply_valid", out_item.reply_valid, expected_replies[0].reply_valid);
        check_field("reply_data", out_item.reply_data, expected_replies[0].reply_data);
        check_field("changed", out_item.changed, expected_replies[0].changed);
        check_field("write_notice", out_item.write_notice, expected_replies[0].write_notice);
        check_field("notice_address", out_item.notice_address,
                    expected_replies[0].notice_address);
        void'(expected_replies.pop_front());
      end
    end
  end

  // watchdog, generous against the slowest legal run plus the clearing pass
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int    i;
    int    burst;
    in_t   t;
    stim_t s;
    cycle_count    = 0;
    mismatch_count = 0;
    random_count   = 0;

    // shadow stores start cleared, matching the clearing pass after reset
    for (i = 0; i < BANK_BYTES; i++) begin
      bank_copy[i] = 8'h00;
      flag_copy[i] = 1'b0;
    end
    for (i = 0; i < TERMINAL_BYTES; i++) begin
      term_copy[i] = 8'h00;
    end
    term_flag   = 1'b0;
    bus_pointer = 8'h00;
    bus_phase   = PH_WAITING;

    // directed rows go first, back to back
    for (i = 0; i < DIRECTED_ROWS; i++) begin
      s.item     = directed_table[i].stim;
      s.typed    = directed_table[i].typed;
      s.golden   = directed_table[i].golden;
      s.idle_pct = 0;
      stim_queue.push_back(s);
    end

    // random part: mostly well-formed bus transfers and local accesses, some noise
    while (random_count < RANDOM_ITEMS) begin
      case ($urandom_range(19, 0))
        0, 1, 2, 3, 4, 5: begin
          // bus write: address phase, pointer, then a short data burst
          t = random_item();
          t.action = ACT_ADDR_WRITE;
          queue_item(t);
          t = random_item();
          t.action = ACT_BYTE_IN;
          t.bus_byte = pick_pointer();
          queue_item(t);
          burst = $urandom_range(6, 1);
          for (i = 0; i < burst; i++) begin
            t = random_item();
            t.action = ACT_BYTE_IN;
            queue_item(t);
          end
        end
        6, 7, 8, 9, 10: begin
          // bus read: set the pointer, turn round, then clock bytes out
          t = random_item();
          t.action = ACT_ADDR_WRITE;
          queue_item(t);
          t = random_item();
          t.action = ACT_BYTE_IN;
          t.bus_byte = pick_pointer();
          queue_item(t);
          t = random_item();
          t.action = ACT_ADDR_READ;
          queue_item(t);
          burst = $urandom_range(5, 0);
          for (i = 0; i < burst; i++) begin
            t = random_item();
            t.action = ACT_BYTE_SENT;
            queue_item(t);
          end
        end
        11, 12, 13, 14, 15, 16: begin
          // one local access, widths leaning towards the legal ones
          t = random_item();
          case ($urandom_range(2, 0))
            0:       t.action = ACT_LOC_READ;
            1:       t.action = ACT_LOC_WRITE;
            default: t.action = ACT_FLAG_QUERY;
          endcase
          t.local_address = pick_local_address();
          if ($urandom_range(9, 0) < 7) begin
            case ($urandom_range(2, 0))
              0:       t.access_width = 3'd1;
              1:       t.access_width = 3'd2;
              default: t.access_width = 3'd4;
            endcase
          end
          queue_item(t);
        end
        default: begin
          // noise, which also breaks up bus transfers part way
          queue_item(random_item());
        end
      endcase
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // drain: everything handed over and every reply back
    while (stim_queue.size() != 0 || start || expected_replies.size() != 0) begin
      @(posedge clk);
    end
    // watch for stray strobes after the last reply
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
